FILE: design/isd_pkg.sv
// shared types, register codes and constants for the spike despeckle filter
package isd_pkg;

    // pixel and register widths
    localparam int PIX_W       = 8;
    localparam int WIDTH_W     = 11;
    localparam int HEIGHT_W    = 16;
    localparam int MARGIN_W    = 8;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 16;
    localparam int MAX_WIDTH_D = 1024;

    // neighbour sum holds up to four pixels
    localparam int SUM_W       = PIX_W + 2;

    // divide by three as multiply by reciprocal, exact for sums of three pixels
    localparam int DIV3_MUL    = 683;
    localparam int DIV3_MUL_W  = 10;
    localparam int DIV3_SHIFT  = 11;

    // register reset values
    localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 11'd30;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 16'd20;
    localparam logic [MARGIN_W-1:0] MARGIN_RST = 8'd1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPIKE_MARGIN = 8'd2;

    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_DRAIN = 1'b1
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [PIX_W-1:0] pixel_in;
    } item_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             frame_end;
    } result_t;

    // which neighbours exist for the pixel being filtered
    typedef struct packed {
        logic up;
        logic down;
        logic left;
        logic right;
    } nb_present_t;

endpackage

FILE: design/isd_ram.sv
// generic single write port ram with registered read
module isd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read, holds while not enabled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: design/isd_filter.sv
// four-neighbour spike test and neighbour mean
module isd_filter (
    input  logic [isd_pkg::PIX_W-1:0]    centre,
    input  logic [isd_pkg::PIX_W-1:0]    up,
    input  logic [isd_pkg::PIX_W-1:0]    down,
    input  logic [isd_pkg::PIX_W-1:0]    left,
    input  logic [isd_pkg::PIX_W-1:0]    right,
    input  isd_pkg::nb_present_t         present,
    input  logic [isd_pkg::MARGIN_W-1:0] margin,
    output logic [isd_pkg::PIX_W-1:0]    filtered
);

    localparam int CMP_W  = isd_pkg::PIX_W + 1;
    localparam int PROD_W = isd_pkg::SUM_W + isd_pkg::DIV3_MUL_W;

    logic [isd_pkg::SUM_W-1:0] sum;
    logic [2:0]                cnt;
    logic                      spike;
    logic [isd_pkg::SUM_W-1:0] mean;
    logic [PROD_W-1:0]         prod;

    // spike exceeds a neighbour by more than the margin
    function automatic logic above(input logic [isd_pkg::PIX_W-1:0] c,
                                   input logic [isd_pkg::PIX_W-1:0] nb,
                                   input logic [isd_pkg::MARGIN_W-1:0] m);
        logic [CMP_W-1:0] lim;
        lim = CMP_W'(nb) + CMP_W'(m);
        return CMP_W'(c) > lim;
    endfunction

    // sum, count and spike over present neighbours
    always_comb
    begin
        sum   = '0;
        cnt   = '0;
        spike = 1'b1;
        if (present.up)
        begin
            sum = sum + isd_pkg::SUM_W'(up);
            cnt = cnt + 3'd1;
            spike = spike & above(centre, up, margin);
        end
        if (present.down)
        begin
            sum = sum + isd_pkg::SUM_W'(down);
            cnt = cnt + 3'd1;
            spike = spike & above(centre, down, margin);
        end
        if (present.left)
        begin
            sum = sum + isd_pkg::SUM_W'(left);
            cnt = cnt + 3'd1;
            spike = spike & above(centre, left, margin);
        end
        if (present.right)
        begin
            sum = sum + isd_pkg::SUM_W'(right);
            cnt = cnt + 3'd1;
            spike = spike & above(centre, right, margin);
        end
    end

    // truncated mean, divide by three through reciprocal
    assign prod = PROD_W'(sum) * PROD_W'(isd_pkg::DIV3_MUL);

    always_comb
    begin
        unique case (cnt)
            3'd1:    mean = sum;
            3'd2:    mean = sum >> 1;
            3'd3:    mean = isd_pkg::SUM_W'(prod >> isd_pkg::DIV3_SHIFT);
            3'd4:    mean = sum >> 2;
            default: mean = isd_pkg::SUM_W'(centre);
        endcase
    end

    assign filtered = (spike && cnt != 3'd0) ? mean[isd_pkg::PIX_W-1:0] : centre;

endmodule

FILE: design/image_spike_despeckle_top.sv
// top level of the raster-order four-neighbour spike despeckle filter
// each transaction is held in the stage one register, and its result in the output register
// throughput: one transaction per cycle unless output stalls; line store reads issue at accept
// line stores are single write, registered read rams; a right-neighbour forward covers width two
// reset: rst_n asynchronous active low clears position, left pixel and handshake state,
// registers return to width 30, height 20, margin 1; line stores need no clearing
module image_spike_despeckle_top #(
    parameter int MAX_WIDTH = isd_pkg::MAX_WIDTH_D
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           item_valid,
    output logic                           item_ready,
    input  isd_pkg::item_t                 item,
    output logic                           result_valid,
    input  logic                           result_ready,
    output isd_pkg::result_t               result,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [isd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [isd_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int IDX_W = $clog2(MAX_WIDTH);
    localparam int CNT_W = $clog2(MAX_WIDTH + 1);
    localparam int PW    = isd_pkg::PIX_W;

    // configuration registers
    logic [isd_pkg::WIDTH_W-1:0]  width_reg;
    logic [isd_pkg::HEIGHT_W-1:0] height_reg;
    logic [isd_pkg::MARGIN_W-1:0] margin_reg;

    // stage one and position state
    logic                         s1_valid_reg;
    isd_pkg::item_t               s1_item_reg;
    logic                         fwd_reg;
    logic [PW-1:0]                fwd_data_reg;
    logic [IDX_W-1:0]             col_reg;
    logic [isd_pkg::HEIGHT_W-1:0] row_reg;
    logic [PW-1:0]                left_reg;
    logic                         out_valid_reg;
    isd_pkg::result_t             out_reg;

    logic [CNT_W-1:0]             w_eff;
    logic [isd_pkg::HEIGHT_W-1:0] h_eff;
    logic [IDX_W-1:0]             c;
    logic                         last_col;
    logic                         raw_phase;
    logic                         act;
    logic                         emits;
    logic                         s1_advance;
    logic                         do_update;
    logic                         accept;
    logic [IDX_W-1:0]             col_next;
    logic [isd_pkg::HEIGHT_W-1:0] row_next;
    logic [IDX_W-1:0]             rd_base;
    logic [IDX_W-1:0]             rd_c;
    logic [IDX_W-1:0]             rd_r;
    logic                         raw_we;
    logic                         filt_we;
    logic                         fwd_next;
    logic [PW-1:0]                centre_rd;
    logic [PW-1:0]                right_rd;
    logic [PW-1:0]                above_rd;
    logic [PW-1:0]                right_val;
    logic [PW-1:0]                f;
    isd_pkg::nb_present_t         present;

    // effective frame size
    always_comb
    begin
        priority if (width_reg < isd_pkg::WIDTH_W'(2))
            w_eff = CNT_W'(2);
        else if (32'(width_reg) > 32'(MAX_WIDTH))
            w_eff = CNT_W'(MAX_WIDTH);
        else
            w_eff = CNT_W'(width_reg);
    end

    assign h_eff = (height_reg < isd_pkg::HEIGHT_W'(2)) ? isd_pkg::HEIGHT_W'(2) : height_reg;

    // current column, clamped to the row
    assign c        = (CNT_W'(col_reg) >= w_eff) ? IDX_W'(w_eff - CNT_W'(1)) : col_reg;
    assign last_col = (CNT_W'(c) == w_eff - CNT_W'(1));

    // decode of the transaction in stage one
    assign raw_phase  = (row_reg < h_eff);
    assign act        = s1_valid_reg && (raw_phase ? (s1_item_reg.op == isd_pkg::OP_PIXEL)
                                                   : (s1_item_reg.op == isd_pkg::OP_DRAIN));
    assign emits      = act && (!raw_phase || row_reg != '0);
    assign s1_advance = s1_valid_reg && (!emits || !out_valid_reg || result_ready);
    assign do_update  = s1_advance && act;

    assign item_ready = !s1_valid_reg || s1_advance;
    assign accept     = item_valid && item_ready;

    // next position
    always_comb
    begin
        col_next = last_col ? '0 : IDX_W'(c + IDX_W'(1));
        row_next = row_reg;
        if (last_col)
        begin
            row_next = raw_phase ? row_reg + isd_pkg::HEIGHT_W'(1) : '0;
        end
    end

    // line store read addresses for the transaction being accepted
    assign rd_base = do_update ? col_next : col_reg;
    assign rd_c    = (CNT_W'(rd_base) >= w_eff) ? IDX_W'(w_eff - CNT_W'(1)) : rd_base;
    assign rd_r    = IDX_W'(rd_c + IDX_W'(1));

    assign raw_we   = do_update && raw_phase;
    assign filt_we  = do_update && emits;
    assign fwd_next = raw_we && (rd_r == c);

    // raw row, one copy per read port
    isd_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_raw_centre (
        .clk     (clk),
        .wr_en   (raw_we),
        .wr_addr (c),
        .wr_data (s1_item_reg.pixel_in),
        .rd_en   (accept),
        .rd_addr (rd_c),
        .rd_data (centre_rd)
    );

    isd_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_raw_right (
        .clk     (clk),
        .wr_en   (raw_we),
        .wr_addr (c),
        .wr_data (s1_item_reg.pixel_in),
        .rd_en   (accept),
        .rd_addr (rd_r),
        .rd_data (right_rd)
    );

    // filtered row above
    isd_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_filt_above (
        .clk     (clk),
        .wr_en   (filt_we),
        .wr_addr (c),
        .wr_data (f),
        .rd_en   (accept),
        .rd_addr (rd_c),
        .rd_data (above_rd)
    );

    assign right_val = fwd_reg ? fwd_data_reg : right_rd;

    // neighbour presence
    assign present.up    = !raw_phase || (row_reg > isd_pkg::HEIGHT_W'(1));
    assign present.down  = raw_phase;
    assign present.left  = (c != '0);
    assign present.right = !last_col;

    isd_filter u_filter (
        .centre   (centre_rd),
        .up       (above_rd),
        .down     (s1_item_reg.pixel_in),
        .left     (left_reg),
        .right    (right_val),
        .present  (present),
        .margin   (margin_reg),
        .filtered (f)
    );

    // configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= isd_pkg::WIDTH_RST;
            height_reg <= isd_pkg::HEIGHT_RST;
            margin_reg <= isd_pkg::MARGIN_RST;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == isd_pkg::CFG_FRAME_WIDTH)
                width_reg <= cfg_data[isd_pkg::WIDTH_W-1:0];
            if (cfg_index == isd_pkg::CFG_FRAME_HEIGHT)
                height_reg <= cfg_data[isd_pkg::HEIGHT_W-1:0];
            if (cfg_index == isd_pkg::CFG_SPIKE_MARGIN)
                margin_reg <= cfg_data[isd_pkg::MARGIN_W-1:0];
        end
    end

    // stage one control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            s1_valid_reg <= item_valid;
        end
    end

    // stage one payload and right-neighbour forward
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg  <= item;
            fwd_reg      <= fwd_next;
            fwd_data_reg <= s1_item_reg.pixel_in;
        end
    end

    // position and left pixel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            left_reg <= '0;
        end
        else if (do_update)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (emits)
            begin
                left_reg <= f;
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_advance && emits)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && emits)
        begin
            out_reg.pixel_out <= f;
            out_reg.frame_end <= !raw_phase && last_col;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

FILE: design/isd_checker.sv
// port-level checks for the despeckle top level, with its bind
module isd_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           item_valid,
    input logic                           item_ready,
    input logic                           result_valid,
    input logic                           result_ready,
    input isd_pkg::result_t               result,
    input logic                           cfg_valid,
    input logic                           cfg_ready
);

    // a stalled result transaction holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // an empty output slot never blocks the input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> item_ready)
        else $error("input stalled with empty output register");

    // a fresh result follows an accepted input transaction
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(item_valid && item_ready, 2))
        else $error("result without a matching input transaction");

    // configuration never back-pressures
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write stalled");

endmodule

bind image_spike_despeckle_top isd_checker u_isd_checker (.*);
